@@ hw/rtl/sbe_pkg.sv @@
// Package: shared types, constants and controller commands for the breakpoint envelope.
package sbe_pkg;

  localparam int unsigned MaxPointsDefault = 64;
  localparam logic [14:0] ShiftLimitReset  = 15'd6144;

  typedef enum logic [1:0] {
    ACT_UPSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Source of the result value.
  typedef enum logic [1:0] {
    KIND_ZERO   = 2'd0,
    KIND_READ   = 2'd1,
    KIND_INTERP = 2'd2
  } res_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SRCH,
    S_CMP,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_LEFT,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_FINISH,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load;        // capture the input item, clear the scan index
    logic      rd_scan;     // read entry at the scan index
    logic      rd_prev;     // read entry scan-1
    logic      rd_next;     // read entry scan+1
    logic      scan_inc;    // advance the scan index
    logic      scan_dec;    // step the scan index down
    logic      scan_top;    // move the scan index to the count
    logic      pos_save;    // keep the search position
    logic      wr_move;     // write the last read entry at scan
    logic      wr_new;      // write the item's point at scan
    logic      wr_over;     // overwrite the shift at scan
    logic      cnt_inc;
    logic      cnt_dec;
    logic      right_cap;   // keep the last read entry as right neighbor
    logic      left_cap;    // form interpolation operands from the left neighbor
    logic      mul;         // form dy * off
    logic      div_start;   // start the divider
    logic      set_result;  // capture the result
    res_kind_t res_kind;
    status_t   res_status;
  } sbe_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    action_t act;
    logic    mag_bad;
    logic    scan_end;   // scan index == count
    logic    scan_zero;
    logic    at_pos;     // scan index == saved search position
    logic    tick_lt;    // read tick < item tick
    logic    tick_eq;
    logic    full;
    logic    empty;
    logic    div_done;
    logic    is_last;    // scan index == count-1
  } sbe_sts_t;

endpackage

@@ hw/rtl/sbe_ctrl.sv @@
// Controller: sequences search, entry shifting and interpolation for one item.
module sbe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  sbe_pkg::sbe_sts_t sts,
  output sbe_pkg::sbe_cmd_t cmd
);
  import sbe_pkg::*;

  state_t    state, state_next;
  status_t   fin_st, fin_st_next;
  res_kind_t fin_kind, fin_kind_next;
  logic      found;

  assign found = !sts.scan_end && sts.tick_eq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fin_st   <= ST_OK;
      fin_kind <= KIND_ZERO;
    end else begin
      state    <= state_next;
      fin_st   <= fin_st_next;
      fin_kind <= fin_kind_next;
    end
  end

  // Search: read entry at scan, then compare; advance while tick below item tick.
  always_comb begin
    state_next    = state;
    fin_st_next   = fin_st;
    fin_kind_next = fin_kind;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next    = S_CHECK;
          fin_st_next   = ST_OK;
          fin_kind_next = KIND_ZERO;
        end
      end
      S_CHECK: begin
        if (sts.act == ACT_NONE || (sts.act == ACT_QUERY && sts.empty)) begin
          state_next = S_FINISH;
        end else if (sts.act == ACT_UPSERT && sts.mag_bad) begin
          state_next  = S_FINISH;
          fin_st_next = ST_RANGE;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_SRCH: state_next = sts.scan_end ? S_DECIDE : S_CMP;
      S_CMP:  state_next = sts.tick_lt ? S_SRCH : S_DECIDE;
      S_DECIDE: begin
        case (sts.act)
          ACT_UPSERT: begin
            if (found) begin
              state_next = S_FINISH;
            end else if (sts.full) begin
              state_next  = S_FINISH;
              fin_st_next = ST_FULL;
            end else begin
              state_next = S_UP_RD;
            end
          end
          ACT_ERASE: begin
            if (found) begin
              state_next = S_DN_RD;
            end else begin
              state_next  = S_FINISH;
              fin_st_next = ST_NOT_FOUND;
            end
          end
          default: begin
            if (sts.scan_end || sts.scan_zero || sts.tick_eq) begin
              state_next    = S_FINISH;
              fin_kind_next = KIND_READ;
            end else begin
              state_next    = S_LEFT;
              fin_kind_next = KIND_INTERP;
            end
          end
        endcase
      end
      S_UP_RD:  state_next = sts.at_pos ? S_FINISH : S_UP_WR;
      S_UP_WR:  state_next = S_UP_RD;
      S_DN_RD:  state_next = sts.is_last ? S_FINISH : S_DN_WR;
      S_DN_WR:  state_next = S_DN_RD;
      S_LEFT:   state_next = S_MUL;
      S_MUL:    state_next = S_DIV_GO;
      S_DIV_GO: state_next = S_DIV;
      S_DIV:    if (sts.div_done) state_next = S_FINISH;
      S_FINISH: state_next = S_OUT;
      S_OUT:    if (out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_OUT);
    case (state)
      S_IDLE:   cmd.load = in_valid;
      S_SRCH:   cmd.rd_scan = !sts.scan_end;
      S_CMP:    cmd.scan_inc = sts.tick_lt;
      S_DECIDE: begin
        case (sts.act)
          ACT_UPSERT: begin
            if (found) begin
              cmd.wr_over = 1'b1;
            end else if (!sts.full) begin
              // Start the upward shift at the free slot above the top entry.
              cmd.pos_save = 1'b1;
              cmd.scan_top = 1'b1;
            end
          end
          ACT_ERASE: ;
          default: begin
            if (sts.scan_end) begin
              cmd.rd_prev = 1'b1;
            end else if (!sts.scan_zero && !sts.tick_eq) begin
              cmd.right_cap = 1'b1;
              cmd.rd_prev   = 1'b1;
            end
          end
        endcase
      end
      S_UP_RD: begin
        if (sts.at_pos) begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.rd_prev = 1'b1;
        end
      end
      S_UP_WR: begin
        cmd.wr_move  = 1'b1;
        cmd.scan_dec = 1'b1;
      end
      S_DN_RD: begin
        if (sts.is_last) cmd.cnt_dec = 1'b1;
        else             cmd.rd_next = 1'b1;
      end
      S_DN_WR: begin
        cmd.wr_move  = 1'b1;
        cmd.scan_inc = 1'b1;
      end
      S_LEFT:   cmd.left_cap = 1'b1;
      S_MUL:    cmd.mul = 1'b1;
      S_DIV_GO: cmd.div_start = 1'b1;
      S_FINISH: begin
        cmd.set_result = 1'b1;
        cmd.res_status = fin_st;
        cmd.res_kind   = fin_kind;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/sbe_div.sv @@
// Serial restoring divider for the interpolation step, floor rounding.
module sbe_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [48:0] num,
  input  logic        [31:0] den,
  output logic               done,
  output logic signed [16:0] quo
);

  localparam int NumW = 48;

  logic [NumW-1:0] q;
  logic [31:0]     rem;
  logic [5:0]      cnt;
  logic            neg, busy;
  logic [32:0]     shifted;
  logic [33:0]     trial;
  logic [NumW:0]   fl;

  assign shifted = {rem, q[NumW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(NumW - 1);
        neg  <= num[48];
        q    <= num[48] ? NumW'(-num) : num[NumW-1:0];
        rem  <= '0;
      end else if (busy) begin
        if (!trial[33]) begin
          rem <= trial[31:0];
          q   <= {q[NumW-2:0], 1'b1};
        end else begin
          rem <= shifted[31:0];
          q   <= {q[NumW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 6'd1;
      end
    end
  end

  // Negative: floor = -(q) - (rem != 0).
  assign fl  = neg ? (-{1'b0, q} - {{NumW{1'b0}}, rem != '0}) : {1'b0, q};
  assign quo = fl[16:0];

endmodule

@@ hw/rtl/sbe_dp.sv @@
// Datapath: point store, scan index, counter, interpolation operands and result.
module sbe_dp #(
  parameter int unsigned MAX_POINTS = sbe_pkg::MaxPointsDefault
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [14:0]            cfg_data,
  input  logic [1:0]             action,
  input  logic [31:0]            point_tick,
  input  logic signed [15:0]     point_shift,
  input  sbe_pkg::sbe_cmd_t      cmd,
  output sbe_pkg::sbe_sts_t      sts,
  output logic [1:0]             status,
  output logic signed [15:0]     value,
  output logic [6:0]             point_count
);
  import sbe_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  logic [31:0] tick_mem  [MAX_POINTS];
  logic [15:0] shift_mem [MAX_POINTS];

  logic [14:0]        limit;
  logic [CW-1:0]      count;
  logic [CW-1:0]      scan;
  logic [CW-1:0]      pos;
  action_t            act;
  logic [31:0]        t_in;
  logic signed [15:0] s_in;
  logic [31:0]        rd_tick;
  logic signed [15:0] rd_shift;
  logic [31:0]        r_tick;
  logic signed [15:0] r_shift;
  logic signed [15:0] l_shift;
  logic signed [16:0] dy;
  logic [31:0]        dx, off;
  logic signed [48:0] prod;
  logic               div_done;
  logic signed [16:0] quo;
  logic signed [16:0] interp_sum;
  logic signed [15:0] res_value;
  logic [16:0]        mag;
  logic               rd_en, wr_en, wr_tick_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [31:0]        wr_tick;
  logic [15:0]        wr_shift;

  assign mag = s_in[15] ? 17'(-{s_in[15], s_in}) : {1'b0, s_in};

  // One read port, one write port.
  always_comb begin
    rd_en   = cmd.rd_scan | cmd.rd_prev | cmd.rd_next;
    rd_addr = scan[AW-1:0];
    if (cmd.rd_prev) rd_addr = AW'(scan - CW'(1));
    if (cmd.rd_next) rd_addr = AW'(scan + CW'(1));
    wr_en      = cmd.wr_move | cmd.wr_new | cmd.wr_over;
    wr_addr    = scan[AW-1:0];
    wr_tick_en = !cmd.wr_over;
    wr_tick    = cmd.wr_new ? t_in : rd_tick;
    wr_shift   = (cmd.wr_new || cmd.wr_over) ? s_in : rd_shift;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tick  <= tick_mem[rd_addr];
      rd_shift <= shift_mem[rd_addr];
    end
    if (wr_en) begin
      if (wr_tick_en) tick_mem[wr_addr] <= wr_tick;
      shift_mem[wr_addr] <= wr_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit       <= ShiftLimitReset;
      count       <= '0;
      status      <= ST_OK;
      value       <= '0;
      point_count <= '0;
    end else begin
      if (cfg_we) limit <= cfg_data;
      if (cmd.cnt_inc) count <= count + CW'(1);
      if (cmd.cnt_dec) count <= count - CW'(1);
      if (cmd.set_result) begin
        point_count <= 7'(count);
        status      <= cmd.res_status;
        value       <= res_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= action_t'(action);
      t_in <= point_tick;
      s_in <= point_shift;
    end
    if (cmd.load)          scan <= '0;
    else if (cmd.scan_inc) scan <= scan + CW'(1);
    else if (cmd.scan_dec) scan <= scan - CW'(1);
    else if (cmd.scan_top) scan <= count;
    if (cmd.pos_save) pos <= scan;
    if (cmd.right_cap) begin
      r_tick  <= rd_tick;
      r_shift <= rd_shift;
    end
    if (cmd.left_cap) begin
      dy      <= 17'(r_shift) - 17'(rd_shift);
      dx      <= r_tick - rd_tick;
      off     <= t_in - rd_tick;
      l_shift <= rd_shift;
    end
    if (cmd.mul) prod <= 49'(dy) * $signed({1'b0, off});
  end

  sbe_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (prod),
    .den  (dx),
    .done (div_done),
    .quo  (quo)
  );

  assign interp_sum = 17'(l_shift) + quo;

  always_comb begin
    case (cmd.res_kind)
      KIND_READ:   res_value = rd_shift;
      KIND_INTERP: res_value = interp_sum[15:0];
      default:     res_value = '0;
    endcase
  end

  always_comb begin
    sts.act       = act;
    sts.mag_bad   = (mag > {2'b00, limit});
    sts.scan_end  = (scan == count);
    sts.scan_zero = (scan == '0);
    sts.at_pos    = (scan == pos);
    sts.tick_lt   = (rd_tick < t_in);
    sts.tick_eq   = (rd_tick == t_in);
    sts.full      = (count == CW'(MAX_POINTS));
    sts.empty     = (count == '0);
    sts.div_done  = div_done;
    sts.is_last   = ((scan + CW'(1)) == count);
  end

endmodule

@@ hw/rtl/sorted_breakpoint_envelope.sv @@
// Top level: sorted breakpoint envelope with piecewise linear query.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------------
//   in       | in_valid / in_ready    | action, point_tick, point_shift
//   out      | out_valid / out_ready  | status, value, point_count
//   cfg      | cfg_we                 | cfg_data (shift_limit)
//
// One item at a time. An item ends early on an unused action, a shift out of range or
// a query of an empty table. Otherwise it scans the points below its tick; an insert or
// erase then moves the entries above its place one by one, and an interpolating query
// waits on the serial divider; the single read port of the point memory sets the search
// and move time.
// Reset clears the point count and loads the default limit; the memory is not cleared.
// The result is held in output registers until taken; a new item waits meanwhile.
module sorted_breakpoint_envelope #(
  parameter int unsigned MAX_POINTS = sbe_pkg::MaxPointsDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [31:0]        point_tick,
  input  logic signed [15:0] point_shift,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [15:0] value,
  output logic [6:0]         point_count
);
  import sbe_pkg::*;

  sbe_cmd_t cmd;
  sbe_sts_t sts;

  sbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbe_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .action     (action),
    .point_tick (point_tick),
    .point_shift(point_shift),
    .cmd        (cmd),
    .sts        (sts),
    .status     (status),
    .value      (value),
    .point_count(point_count)
  );

endmodule

@@ hw/rtl/sbe_checker.sv @@
// Checker: port-level properties of the breakpoint envelope, bound to the top level.
module sbe_env_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] value,
  input logic [6:0]  point_count
);
  import sbe_pkg::*;

  // A waiting result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(status) &&
    $stable(point_count))
    else $error("result changed while stalled");

  // No new item while a result is pending.
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while result pending");

  // Failed status carries a zero value.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> value == '0)
    else $error("nonzero value with error status");

  // Reset leaves the block idle and ready for an item.
  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind sorted_breakpoint_envelope sbe_env_checker u_sbe_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .status(status),
  .value(value), .point_count(point_count)
);
